@@ hw/rtl/spq_pkg.sv @@
// shared constants and types for the sorted priority queue
package spq_pkg;

    // queue geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // stream beat widths, padded to whole bytes
    localparam int IN_BITS   = OP_W + VALUE_W + PRIO_W;
    localparam int OUT_BITS  = VALUE_W + PRIO_W + STAT_W + COUNT_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_HEAD = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_TAIL = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // one stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming beat
        logic exec;   // apply the captured operation and load the result
    } t_dp_cmd;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
// controller for the sorted priority queue: capture / execute sequencing and result valid
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_m_tvalid;
    logic n_m_tvalid;
    logic out_free;

    // output register is free when empty or being drained this cycle
    assign out_free   = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.exec = (r_state == ST_EXEC) && out_free;
    end

    // next state and result valid
    always_comb begin
        n_state    = r_state;
        n_m_tvalid = r_m_tvalid;
        if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state    = ST_IDLE;
                    n_m_tvalid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

endmodule

@@ hw/rtl/spq_datapath.sv @@
// datapath for the sorted priority queue: sorted cell array, occupancy and result register
module spq_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spq_pkg::t_dp_cmd                i_cmd,
    input  logic [spq_pkg::IN_DATA_W-1:0]   i_in_data,
    output logic [spq_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import spq_pkg::*;

    // captured beat
    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [PRIO_W-1:0]  r_prio;

    // sorted cells, head at index 0
    t_entry r_cell [CAPACITY];
    t_entry n_cell [CAPACITY];
    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] n_occ;

    // result register
    logic signed [VALUE_W-1:0] r_rm_value;
    logic signed [PRIO_W-1:0]  r_rm_prio;
    logic [STAT_W-1:0]         r_status;
    logic signed [VALUE_W-1:0] n_rm_value;
    logic signed [PRIO_W-1:0]  n_rm_prio;
    logic [STAT_W-1:0]         n_status;

    logic [CAPACITY-1:0] ge;
    logic [CAPACITY-1:0] prev_ge;
    t_entry prev_cell [CAPACITY];
    t_entry new_entry;
    logic [CNT_W-1:0] occ_m1;
    logic is_full;
    logic is_empty;

    assign new_entry.prio  = r_prio;
    assign new_entry.value = r_value;
    assign occ_m1   = r_occ - CNT_W'(1);
    assign is_full  = (r_occ >= CNT_W'(CAPACITY));
    assign is_empty = (r_occ == '0);

    // per-cell compare: an empty cell counts as greater than any priority
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) < r_occ) begin
                ge[i] = (r_cell[i].prio >= r_prio);
            end else begin
                ge[i] = 1'b1;
            end
        end
        prev_ge[0]   = 1'b0;
        prev_cell[0] = new_entry;
        for (int i = 1; i < CAPACITY; i++) begin
            prev_ge[i]   = ge[i-1];
            prev_cell[i] = r_cell[i-1];
        end
    end

    // next cell contents, occupancy and result
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
        end
        n_occ      = r_occ;
        n_rm_value = '0;
        n_rm_prio  = '0;
        n_status   = STAT_OK;
        case (r_op)
            OP_INSERT: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    // cells at or past the insert point shift toward the tail
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (ge[i]) begin
                            n_cell[i] = prev_ge[i] ? prev_cell[i] : new_entry;
                        end
                    end
                    n_occ = r_occ + CNT_W'(1);
                end
            end
            OP_POP_HEAD: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_rm_value = r_cell[0].value;
                    n_rm_prio  = r_cell[0].prio;
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_cell[i] = r_cell[i+1];
                    end
                    n_occ = occ_m1;
                end
            end
            OP_POP_TAIL: begin
                if (is_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_rm_value = r_cell[occ_m1[IDX_W-1:0]].value;
                    n_rm_prio  = r_cell[occ_m1[IDX_W-1:0]].prio;
                    n_occ      = occ_m1;
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    // beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_data[OP_W-1:0];
            r_value <= i_in_data[OP_W +: VALUE_W];
            r_prio  <= i_in_data[OP_W + VALUE_W +: PRIO_W];
        end
    end

    // cells and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cell[i] <= n_cell[i];
            end
            r_rm_value <= n_rm_value;
            r_rm_prio  <= n_rm_prio;
            r_status   <= n_status;
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.exec) begin
            r_occ <= n_occ;
        end
    end

    // pack the result beat
    assign o_out_data = {
        (OUT_DATA_W - OUT_BITS)'(0),
        COUNT_W'(r_occ),
        r_status,
        r_rm_prio,
        r_rm_value
    };

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted priority queue, top level.
// Input stream (s side) carries one operation per beat: insert, remove head
// (lowest priority) or remove tail (highest priority). Output stream (m side)
// returns exactly one result beat per operation: removed entry (zero if none),
// status (ok, empty, full) and the entry count after the operation.
// Up to 16 entries are held in a row of cells kept in ascending priority
// order; every cell compares against the incoming priority in parallel, so an
// insert or removal is applied at once in the execute state.
// Each operation is first captured from the beat, then executed.
// The result is valid the cycle after execute; a new operation is not accepted
// while the previous one is still in execute, as set by the capture/execute controller.
// Reset empties the queue (count zero); cell contents are not cleared and are
// never read until written.
// If the receiver stalls, the result beat holds; one more operation can be
// captured and waits in execute until the result register drains; meanwhile
// s_tready stays low.
module sorted_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // op[1:0], item_value[33:2], item_priority[49:34], zero pad [55:50]
    input  logic [spq_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // removed_value[31:0], removed_priority[47:32], status[49:48],
    // entry_count[54:50], zero pad [55]
    output logic [spq_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import spq_pkg::*;

    t_dp_cmd cmd;

    // sequencing
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // storage and compare
    spq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_s_tdata),
        .o_out_data (o_m_tdata)
    );

endmodule

@@ dv/tb_sorted_priority_queue.sv @@
// self-checking stream testbench for the sorted priority queue
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    // unused op code, the block treats it as no operation
    localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

    localparam int RANDOM_ITEMS = 500;
    localparam int PLAN_OPS     = 546;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // one result beat, split into fields
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        count;
    } t_result;

    // one row of directed stimulus; fixed rows carry a hand-typed result
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
        int                 reps;
        bit                 fixed;
        t_result            want;
    } t_row;

    localparam int DIR_ROWS_N = 21;
    localparam t_row DIR_ROWS [0:DIR_ROWS_N-1] = '{
        // removals and no-op on the empty queue after reset
        '{OP_POP_HEAD, 32'h0000_0000, 16'h0000, 1, 1'b1, '{'0, '0, STAT_EMPTY, 5'd0}},
        '{OP_POP_TAIL, 32'h0000_0000, 16'h0000, 1, 1'b1, '{'0, '0, STAT_EMPTY, 5'd0}},
        '{OP_IDLE,     32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, '{'0, '0, STAT_OK,    5'd0}},
        // extreme values and priorities
        '{OP_INSERT,   32'h7FFF_FFFF, 16'h7FFF, 1, 1'b1, '{'0, '0, STAT_OK,    5'd1}},
        '{OP_INSERT,   32'h8000_0000, 16'h8000, 1, 1'b1, '{'0, '0, STAT_OK,    5'd2}},
        '{OP_INSERT,   32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, '{'0, '0, STAT_OK,    5'd3}},
        '{OP_INSERT,   32'h0000_0000, 16'h0000, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        // equal priority goes ahead of the stored one
        '{OP_INSERT,   32'h0000_0001, 16'h0000, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        // equal to the head becomes the new head
        '{OP_INSERT,   32'h0000_0002, 16'h8000, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        // equal to the tail lands just before it
        '{OP_INSERT,   32'h0000_0003, 16'h7FFF, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        '{OP_POP_HEAD, 32'h0000_0000, 16'h0000, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        '{OP_POP_TAIL, 32'h0000_0000, 16'h0000, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        '{OP_IDLE,     32'h1234_5678, 16'h4321, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        // fill up with descending priorities
        '{OP_INSERT,   32'h0000_0100, 16'h0010, 12, 1'b0, '{'0, '0, STAT_OK,   5'd0}},
        // insert into the full queue
        '{OP_INSERT,   32'hDEAD_BEEF, 16'h0005, 1, 1'b1, '{'0, '0, STAT_FULL,  5'd16}},
        '{OP_IDLE,     32'h0000_0000, 16'h0000, 1, 1'b1, '{'0, '0, STAT_OK,    5'd16}},
        // drain from both ends
        '{OP_POP_HEAD, 32'h0000_0000, 16'h0000, 8, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        '{OP_POP_TAIL, 32'h0000_0000, 16'h0000, 8, 1'b0, '{'0, '0, STAT_OK,    5'd0}},
        '{OP_POP_TAIL, 32'h0000_0000, 16'h0000, 1, 1'b1, '{'0, '0, STAT_EMPTY, 5'd0}},
        '{OP_INSERT,   32'h5A5A_A5A5, 16'h1234, 1, 1'b1, '{'0, '0, STAT_OK,    5'd1}},
        '{OP_POP_TAIL, 32'h0000_0000, 16'h0000, 1, 1'b0, '{'0, '0, STAT_OK,    5'd0}}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // predictor state: entries in ascending priority order
    logic signed [VALUE_W-1:0] shadow_value [CAPACITY];
    logic signed [PRIO_W-1:0]  shadow_prio  [CAPACITY];
    int                        shadow_count = 0;

    t_result pending_results [$];

    int sender_idle_pct    = 30;
    int receiver_stall_pct = 72;
    int ops_sent           = 0;
    int results_seen       = 0;
    int err_count          = 0;
    int op_hits [4]        = '{0, 0, 0, 0};
    int full_hits          = 0;
    int empty_hits         = 0;
    int peak_depth         = 0;

    sorted_priority_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // failure bookkeeping, only the first few are printed
    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // apply one operation to the shadow queue and work out its result
    function automatic t_result sorted_queue_step(input logic [OP_W-1:0] op,
                                                  input logic signed [VALUE_W-1:0] value,
                                                  input logic signed [PRIO_W-1:0] prio);
        t_result res;
        int      pos;
        res = '{'0, '0, STAT_OK, '0};
        case (op)
            OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    // first slot whose priority is equal or greater
                    pos = shadow_count;
                    for (int i = shadow_count - 1; i >= 0; i--) begin
                        if (shadow_prio[i] >= prio) pos = i;
                    end
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_value[i] = shadow_value[i-1];
                        shadow_prio[i]  = shadow_prio[i-1];
                    end
                    shadow_value[pos] = value;
                    shadow_prio[pos]  = prio;
                    shadow_count++;
                end
            end
            OP_POP_HEAD: begin
                if (shadow_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.value = shadow_value[0];
                    res.prio  = shadow_prio[0];
                    for (int i = 1; i < shadow_count; i++) begin
                        shadow_value[i-1] = shadow_value[i];
                        shadow_prio[i-1]  = shadow_prio[i];
                    end
                    shadow_count--;
                end
            end
            OP_POP_TAIL: begin
                if (shadow_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.value = shadow_value[shadow_count-1];
                    res.prio  = shadow_prio[shadow_count-1];
                    shadow_count--;
                end
            end
            default: begin
            end
        endcase
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // drive one operation beat, wait for acceptance, queue its expected result
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [PRIO_W-1:0] prio, input bit fixed,
                            input t_result want);
        logic [IN_DATA_W-1:0] beat;
        t_result              res;
        // idle regime follows progress through the run
        if (ops_sent * 3 < PLAN_OPS) begin
            sender_idle_pct    = 30;
            receiver_stall_pct = 72;
        end else if (ops_sent * 3 < 2 * PLAN_OPS) begin
            sender_idle_pct    = 72;
            receiver_stall_pct = 30;
        end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        beat = '0;
        beat[0 +: OP_W]              = op;
        beat[OP_W +: VALUE_W]        = value;
        beat[OP_W+VALUE_W +: PRIO_W] = prio;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // beat accepted at this edge
        res = sorted_queue_step(op, value, prio);
        pending_results.push_back(fixed ? want : res);
        ops_sent++;
        op_hits[op]++;
        if (res.status == STAT_FULL) full_hits++;
        if (res.status == STAT_EMPTY) empty_hits++;
        if (shadow_count > peak_depth) peak_depth = shadow_count;
    endtask

    // receiver: random stalls, check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            // fields sit from the lowest bit up
            got.value  = o_m_tdata[0 +: VALUE_W];
            got.prio   = o_m_tdata[VALUE_W +: PRIO_W];
            got.status = o_m_tdata[VALUE_W+PRIO_W +: STAT_W];
            got.count  = o_m_tdata[VALUE_W+PRIO_W+STAT_W +: COUNT_W];
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result beat with nothing expected: %h", got));
            end else begin
                exp_res = pending_results.pop_front();
                if (got.value !== exp_res.value || got.prio !== exp_res.prio ||
                    got.status !== exp_res.status || got.count !== exp_res.count) begin
                    flag_error($sformatf(
                        {"result %0d: exp value %h prio %h status %0d count %0d, ",
                         "got value %h prio %h status %0d count %0d"},
                        results_seen, exp_res.value, exp_res.prio, exp_res.status,
                        exp_res.count, got.value, got.prio, got.status, got.count));
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // stimulus: directed table, then biased random traffic
    initial begin
        int                  insert_bias;
        int                  roll;
        logic [OP_W-1:0]     op;
        logic [PRIO_W-1:0]   prio;
        logic [PRIO_W-1:0]   corner_prio [4];
        corner_prio = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
        insert_bias = 50;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS_N; r++) begin
            for (int k = 0; k < DIR_ROWS[r].reps; k++) begin
                issue_op(DIR_ROWS[r].op, DIR_ROWS[r].value + VALUE_W'(k),
                         DIR_ROWS[r].prio - PRIO_W'(k),
                         DIR_ROWS[r].fixed, DIR_ROWS[r].want);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // swing between filling and draining so full and empty both recur
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       insert_bias = 80;
                    1:       insert_bias = 25;
                    default: insert_bias = 55;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 4) begin
                op = OP_IDLE;
            end else if (roll < 4 + insert_bias * 96 / 100) begin
                op = OP_INSERT;
            end else begin
                op = $urandom_range(1) ? OP_POP_HEAD : OP_POP_TAIL;
            end
            // mix of full-range, clustered and corner priorities
            case ($urandom_range(3))
                0:       prio = PRIO_W'($urandom());
                1:       prio = 16'($urandom_range(4)) - 16'd2;
                2:       prio = corner_prio[$urandom_range(3)];
                default: prio = {3'($urandom_range(7)), 13'($urandom_range(3))};
            endcase
            issue_op(op, $urandom(), prio, 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d ops: %0d inserts, %0d head and %0d tail removals, %0d no-ops",
                 ops_sent, op_hits[OP_INSERT], op_hits[OP_POP_HEAD], op_hits[OP_POP_TAIL],
                 op_hits[OP_IDLE]);
        $display("%0d results checked, %0d full and %0d empty rejections, peak depth %0d",
                 results_seen, full_hits, empty_hits, peak_depth);
        if (err_count == 0) begin
            $display("tb_sorted_priority_queue passed");
        end else begin
            $display("%0d errors", err_count);
            $display("tb_sorted_priority_queue failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("tb_sorted_priority_queue failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue.sv
dv/tb_sorted_priority_queue.sv
